// ----- design/rational_arithmetic_unit_top_macros.svh -----
// Assertion macros shared by the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH

// a condition implies a consequence in the same cycle
`define RAU_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// a condition implies a consequence in the next cycle
`define RAU_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WIDTH  = 32;
    localparam int PROD_W = 2 * WIDTH;
    localparam int CNT_W  = $clog2(PROD_W + 1);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIVZERO  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // classified operands as handed from front to back
    typedef struct packed {
        op_t                op;
        logic               zero_den;
        logic               sa;
        logic               sb;
        logic [WIDTH-1:0]   ma;
        logic [WIDTH-1:0]   da;
        logic [WIDTH-1:0]   mb;
        logic [WIDTH-1:0]   db;
    } job_t;

    // queue occupancy seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- design/rau_front.sv -----
// ----------------------------------------------------------------------------
// rau_front
// Takes input beats, moves signs to numerators, splits off magnitudes.
// ----------------------------------------------------------------------------
module rau_front (
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  req_type,
    input  logic signed [31:0]          a_num,
    input  logic signed [31:0]          a_den,
    input  logic signed [31:0]          b_num,
    input  logic signed [31:0]          b_den,
    input  rau_pkg::q_stat_t            q_stat,
    output logic                        push,
    output rau_pkg::job_t               job
);

    logic [rau_pkg::WIDTH-1:0] an, ad, bn, bd;

    function automatic logic [rau_pkg::WIDTH-1:0] mag(input logic [rau_pkg::WIDTH-1:0] x);
        mag = x[rau_pkg::WIDTH-1] ? (~x + 1'b1) : x;
    endfunction

    assign an = a_num[rau_pkg::WIDTH-1:0];
    assign ad = a_den[rau_pkg::WIDTH-1:0];
    assign bn = b_num[rau_pkg::WIDTH-1:0];
    assign bd = b_den[rau_pkg::WIDTH-1:0];

    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

    always_comb
    begin
        job.op       = rau_pkg::op_t'(req_type);
        job.zero_den = (ad == '0) || (bd == '0);
        job.ma       = mag(an);
        job.da       = mag(ad);
        job.mb       = mag(bn);
        job.db       = mag(bd);
        job.sa       = (an[rau_pkg::WIDTH-1] ^ ad[rau_pkg::WIDTH-1]) && (an != '0);
        job.sb       = (bn[rau_pkg::WIDTH-1] ^ bd[rau_pkg::WIDTH-1]) && (bn != '0);
    end

endmodule

// ----- design/rau_queue.sv -----
// ----------------------------------------------------------------------------
// rau_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module rau_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rau_pkg::job_t       push_job,
    input  logic                pop,
    output rau_pkg::job_t       head_job,
    output rau_pkg::q_stat_t    q_stat
);

    rau_pkg::job_t  mem_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    assign head_job     = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == 2'd2);
    assign q_stat.empty = (cnt_reg == 2'd0);

    `include "rational_arithmetic_unit_top_macros.svh"

    `RAU_ASSERT_IMP(a_no_overrun, clk, rst_n, q_stat.full, !push, "push into full queue")
    `RAU_ASSERT_IMP(a_no_underrun, clk, rst_n, q_stat.empty, !pop, "pop from empty queue")
    `RAU_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg != 2'd3, "queue count out of range")

endmodule

// ----- design/rau_back.sv -----
// ----------------------------------------------------------------------------
// rau_back
// Sequencer: cross products, compare, combine, binary gcd, two restoring divides.
// ----------------------------------------------------------------------------
module rau_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rau_pkg::q_stat_t            q_stat,
    input  rau_pkg::job_t               head_job,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [31:0]          res_num,
    output logic [30:0]                 res_den,
    output logic                        a_less_b,
    output logic                        a_equal_b,
    output logic [1:0]                  status
);

    localparam int W  = rau_pkg::WIDTH;
    localparam int PW = rau_pkg::PROD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_CMP, S_COMB, S_GCD, S_DIVN, S_DIVD, S_FIN, S_OUT
    } state_t;

    state_t              state_reg;
    rau_pkg::job_t       job_reg;
    logic [PW-1:0]       xa_reg, xb_reg, rmag_reg, rden_reg;
    logic [PW-1:0]       gx_reg, gy_reg, g_reg;
    logic [PW-1:0]       quo_reg, rem_reg, dvd_reg;
    logic [rau_pkg::CNT_W-1:0] cnt_reg;
    logic                rneg_reg, lt_reg, eq_reg;
    logic [31:0]         res_num_reg;
    logic [30:0]         res_den_reg;
    logic [1:0]          status_reg;
    logic [PW-1:0]       half;

    logic [PW-1:0]       rem_sh, gdiff, quo_next, rem_next;
    logic                sb2;

    // g times two to the shared power already collected in g
    function automatic logic [PW-1:0] shl_g(input logic [PW-1:0] odd_part,
                                            input logic [PW-1:0] pow2);
        logic [PW-1:0] r;
        r = '0;
        for (int i = 0; i < PW; i++)
            if (pow2[i])
                r = odd_part << i;
        shl_g = r;
    endfunction

    assign half = {{(PW-1){1'b0}}, 1'b1} << (W - 1);
    assign rem_sh   = {rem_reg[PW-2:0], dvd_reg[PW-1]};
    assign quo_next = {quo_reg[PW-2:0], (rem_sh >= g_reg)};
    assign rem_next = (rem_sh >= g_reg) ? rem_sh - g_reg : rem_sh;
    assign gdiff  = (gx_reg > gy_reg) ? gx_reg - gy_reg : gy_reg - gx_reg;
    assign sb2    = ((job_reg.op == rau_pkg::OP_SUB) ? !job_reg.sb : job_reg.sb)
                    && (xb_reg != '0);

    assign pop       = (state_reg == S_IDLE) && !q_stat.empty;
    assign out_valid = (state_reg == S_OUT);
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign a_less_b  = lt_reg;
    assign a_equal_b = eq_reg;
    assign status    = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg) inside
                S_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        job_reg   <= head_job;
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    xa_reg    <= {{W{1'b0}}, job_reg.ma} * {{W{1'b0}}, job_reg.db};
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    xb_reg    <= {{W{1'b0}}, job_reg.mb} * {{W{1'b0}}, job_reg.da};
                    rden_reg  <= {{W{1'b0}}, job_reg.da} * {{W{1'b0}}, job_reg.db};
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    // signed compare of cross products via signs and magnitudes
                    eq_reg <= !job_reg.zero_den && (job_reg.sa == job_reg.sb)
                              && (xa_reg == xb_reg);
                    lt_reg <= !job_reg.zero_den &&
                              ((job_reg.sa && !job_reg.sb) ||
                               (!job_reg.sa && !job_reg.sb && xa_reg < xb_reg) ||
                               (job_reg.sa && job_reg.sb && xa_reg > xb_reg));
                    if (job_reg.zero_den ||
                        (job_reg.op == rau_pkg::OP_DIV && job_reg.mb == '0))
                    begin
                        status_reg  <= rau_pkg::ST_DIVZERO;
                        res_num_reg <= '0;
                        res_den_reg <= 31'd1;
                        state_reg   <= S_OUT;
                    end
                    else
                        state_reg <= S_COMB;
                end
                S_COMB:
                begin
                    unique case (job_reg.op) inside
                        rau_pkg::OP_ADD, rau_pkg::OP_SUB:
                        begin
                            if (job_reg.sa == sb2)
                            begin
                                rneg_reg <= job_reg.sa;
                                rmag_reg <= xa_reg + xb_reg;
                            end
                            else if (xa_reg >= xb_reg)
                            begin
                                rneg_reg <= job_reg.sa;
                                rmag_reg <= xa_reg - xb_reg;
                            end
                            else
                            begin
                                rneg_reg <= sb2;
                                rmag_reg <= xb_reg - xa_reg;
                            end
                        end
                        rau_pkg::OP_MUL:
                        begin
                            rneg_reg <= job_reg.sa ^ job_reg.sb;
                            rmag_reg <= {{W{1'b0}}, job_reg.ma} * {{W{1'b0}}, job_reg.mb};
                        end
                        default:
                        begin
                            rneg_reg <= job_reg.sa ^ job_reg.sb;
                            rmag_reg <= xa_reg;
                            rden_reg <= {{W{1'b0}}, job_reg.da} * {{W{1'b0}}, job_reg.mb};
                        end
                    endcase
                    state_reg <= S_GCD;
                    cnt_reg   <= '0;
                end
                S_GCD:
                begin
                    // subtractive gcd with shared power-of-two stripping
                    if (cnt_reg == '0)
                    begin
                        if (rmag_reg == '0)
                        begin
                            status_reg  <= rau_pkg::ST_OK;
                            res_num_reg <= '0;
                            res_den_reg <= 31'd1;
                            state_reg   <= S_OUT;
                        end
                        else
                        begin
                            gx_reg  <= rmag_reg;
                            gy_reg  <= rden_reg;
                            g_reg   <= {{(PW-1){1'b0}}, 1'b1};
                            cnt_reg <= {{(rau_pkg::CNT_W-1){1'b0}}, 1'b1};
                        end
                    end
                    else if (gx_reg == gy_reg)
                    begin
                        g_reg     <= shl_g(gx_reg, g_reg);
                        dvd_reg   <= rmag_reg;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIVN;
                    end
                    else if (!gx_reg[0] && !gy_reg[0])
                    begin
                        gx_reg <= gx_reg >> 1;
                        gy_reg <= gy_reg >> 1;
                        g_reg  <= g_reg << 1;
                    end
                    else if (!gx_reg[0])
                        gx_reg <= gx_reg >> 1;
                    else if (!gy_reg[0])
                        gy_reg <= gy_reg >> 1;
                    else if (gx_reg > gy_reg)
                        gx_reg <= gdiff >> 1;
                    else
                        gy_reg <= gdiff >> 1;
                end
                S_DIVN, S_DIVD:
                begin
                    // restoring divide by g, one quotient bit per cycle
                    if (cnt_reg == rau_pkg::CNT_W'(PW - 1))
                    begin
                        cnt_reg <= '0;
                        if (state_reg == S_DIVN)
                        begin
                            rmag_reg  <= quo_next;
                            dvd_reg   <= rden_reg;
                            rem_reg   <= '0;
                            quo_reg   <= '0;
                            state_reg <= S_DIVD;
                        end
                        else
                        begin
                            quo_reg   <= quo_next;
                            state_reg <= S_FIN;
                        end
                    end
                    else
                    begin
                        rem_reg <= rem_next;
                        quo_reg <= quo_next;
                        dvd_reg <= dvd_reg << 1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_FIN:
                begin
                    // quo_reg now holds reduced denominator
                    if (quo_reg > half - 1'b1 ||
                        (rneg_reg ? rmag_reg > half : rmag_reg > half - 1'b1))
                    begin
                        status_reg  <= rau_pkg::ST_OVERFLOW;
                        res_num_reg <= '0;
                        res_den_reg <= 31'd1;
                    end
                    else
                    begin
                        status_reg  <= rau_pkg::ST_OK;
                        res_num_reg <= rneg_reg ? 32'(~rmag_reg + 1'b1) : rmag_reg[31:0];
                        res_den_reg <= quo_reg[30:0];
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    `include "rational_arithmetic_unit_top_macros.svh"

    `RAU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(res_num), "result changed while stalled")
    `RAU_ASSERT_IMP(a_den_pos, clk, rst_n, out_valid, res_den != '0, "zero result denominator")
    `RAU_ASSERT_IMP(a_flags_excl, clk, rst_n, out_valid, !(a_less_b && a_equal_b), "less and equal both set")

endmodule

// ----- design/rational_arithmetic_unit_top.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Exact add, subtract, multiply and divide of two fractions, reduced by gcd.
// ----------------------------------------------------------------------------
// channel   signals                                   direction
// input     in_valid, in_stall, req_type, a/b num/den  into block
// output    out_valid, out_stall, res_*, flags, status out of block
//
// A normal item runs through the cross products, compare, combine step,
// binary gcd loop and two 64-bit restoring divides by the gcd. A zero
// denominator or divisor exits after the compare, a zero result at the
// first gcd step. The back sequencer handles one item at a time; a two-entry
// queue lets the front take beats while the back works, and the input stalls
// only when the queue is full. Reset clears the sequencer state and the
// queue pointers and count. A stalled result holds until taken.
module rational_arithmetic_unit_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic signed [31:0]  a_num,
    input  logic signed [31:0]  a_den,
    input  logic signed [31:0]  b_num,
    input  logic signed [31:0]  b_den,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  res_num,
    output logic [30:0]         res_den,
    output logic                a_less_b,
    output logic                a_equal_b,
    output logic [1:0]          status
);

    rau_pkg::q_stat_t   q_stat;
    rau_pkg::job_t      push_job, head_job;
    logic               push, pop;

    rau_front u_front (
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .a_num(a_num), .a_den(a_den),
        .b_num(b_num), .b_den(b_den), .q_stat(q_stat),
        .push(push), .job(push_job)
    );

    rau_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_job(push_job),
        .pop(pop), .head_job(head_job), .q_stat(q_stat)
    );

    rau_back u_back (
        .clk(clk), .rst_n(rst_n), .q_stat(q_stat), .head_job(head_job),
        .pop(pop), .out_valid(out_valid), .out_stall(out_stall),
        .res_num(res_num), .res_den(res_den), .a_less_b(a_less_b),
        .a_equal_b(a_equal_b), .status(status)
    );

endmodule
